// ===== rtl/core/b64d_pkg.sv =====
// Shared types and constants of the Base64 decoder.
`default_nettype none
package b64d_pkg;

  // Queue between the front and back parts.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // tuser bit positions on the result channel.
  localparam int UserByteValid = 0;
  localparam int UserStopped   = 1;

  // One queued burst: up to three results from one character.
  typedef struct packed {
    logic [23:0] word;     // first byte in [23:16]
    logic [1:0]  nres;     // results in this burst, 1..3
    logic        eom;      // burst closes the message
    logic        stopped;  // decoding was cut short (meaningful with eom)
    logic        empty;    // end marker without a byte
  } b64d_entry_t;

  // Queue status seen by the back part.
  typedef struct packed {
    logic nonempty;
    logic full;
  } b64d_qstat_t;

endpackage
`default_nettype wire

// ===== rtl/core/b64d_front.sv =====
// Front part: classifies characters, gathers sextets, builds result bursts.
`default_nettype none
module b64d_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [7:0]            in_char,
  input  wire logic                  in_last,
  output logic                       push,
  output b64d_pkg::b64d_entry_t      entry
);

  logic [17:0] held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        stop_r, stop_nxt;

  logic        is_alpha;
  logic [5:0]  sextet;

  // ASCII classification, C locale
  always_comb begin
    is_alpha = 1'b1;
    sextet   = 6'd0;
    if (in_char >= 8'h41 && in_char <= 8'h5A) begin
      sextet = 6'(in_char - 8'd65);
    end else if (in_char >= 8'h61 && in_char <= 8'h7A) begin
      sextet = 6'(in_char - 8'd71);
    end else if (in_char >= 8'h30 && in_char <= 8'h39) begin
      sextet = 6'(in_char + 8'd4);
    end else if (in_char == 8'h2B) begin
      sextet = 6'd62;
    end else if (in_char == 8'h2F) begin
      sextet = 6'd63;
    end else begin
      is_alpha = 1'b0;
    end
  end

  always_comb begin
    held_nxt      = held_r;
    cnt_nxt       = cnt_r;
    stop_nxt      = stop_r;
    entry.word    = 24'd0;
    entry.nres    = 2'd1;
    entry.eom     = 1'b0;
    entry.stopped = 1'b0;
    entry.empty   = 1'b0;
    push          = 1'b0;

    if (!stop_r) begin
      if (!is_alpha) begin
        stop_nxt = 1'b1;
      end else if (cnt_r == 2'd3) begin
        entry.word = {held_r, sextet};
        entry.nres = 2'd3;
        push       = 1'b1;
        held_nxt   = 18'd0;
        cnt_nxt    = 2'd0;
      end else begin
        held_nxt = {held_r[11:0], sextet};
        cnt_nxt  = cnt_r + 2'd1;
      end
    end

    if (in_last) begin
      if (!push) begin
        if (cnt_nxt == 2'd2) begin
          entry.word = {held_nxt[11:4], 16'd0};
          entry.nres = 2'd1;
        end else if (cnt_nxt == 2'd3) begin
          entry.word = {held_nxt[17:2], 8'd0};
          entry.nres = 2'd2;
        end else begin
          entry.nres  = 2'd1;
          entry.empty = 1'b1;
        end
      end
      push          = 1'b1;
      entry.eom     = 1'b1;
      entry.stopped = stop_nxt;
      held_nxt      = 18'd0;
      cnt_nxt       = 2'd0;
      stop_nxt      = 1'b0;
    end

    if (!accept) begin
      push     = 1'b0;
      held_nxt = held_r;
      cnt_nxt  = cnt_r;
      stop_nxt = stop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 18'd0;
      cnt_r  <= 2'd0;
      stop_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/b64d_queue.sv =====
// Short burst queue between front and back parts.
`default_nettype none
module b64d_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire b64d_pkg::b64d_entry_t wr_entry,
  input  wire logic                  pop,
  output b64d_pkg::b64d_entry_t      rd_entry,
  output b64d_pkg::b64d_qstat_t      stat
);

  b64d_pkg::b64d_entry_t              mem_r [b64d_pkg::QDepth];
  logic [b64d_pkg::QPtrW-1:0]         wr_ptr_r, rd_ptr_r;
  logic [b64d_pkg::QCntW-1:0]         cnt_r, cnt_nxt;

  assign stat.nonempty = (cnt_r != '0);
  assign stat.full     = (cnt_r == b64d_pkg::QCntW'(b64d_pkg::QDepth));
  assign rd_entry      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.nonempty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= b64d_pkg::QCntW'(b64d_pkg::QDepth))
    else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/core/b64d_back.sv =====
// Back part: unrolls queued bursts into single results behind an output register.
`default_nettype none
module b64d_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire b64d_pkg::b64d_entry_t q_entry,
  input  wire b64d_pkg::b64d_qstat_t q_stat,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast,
  output logic [1:0]                 out_tuser
);

  b64d_pkg::b64d_entry_t cur_r;
  logic        busy_r;
  logic [1:0]  idx_r;
  logic        oval_r;
  logic [7:0]  odata_r;
  logic        olast_r;
  logic [1:0]  ouser_r;

  logic        advance, cur_done, res_last;
  logic [7:0]  res_byte;

  assign advance  = busy_r && (!oval_r || out_tready);
  assign res_last = (idx_r == cur_r.nres - 2'd1);
  assign cur_done = advance && res_last;
  assign q_pop    = q_stat.nonempty && (!busy_r || cur_done);

  always_comb begin
    case (idx_r)
      2'd0:    res_byte = cur_r.word[23:16];
      2'd1:    res_byte = cur_r.word[15:8];
      2'd2:    res_byte = cur_r.word[7:0];
      default: res_byte = 8'd0;
    endcase
    if (cur_r.empty) res_byte = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_entry;
    end
    if (advance) begin
      odata_r <= res_byte;
      olast_r <= cur_r.eom && res_last;
      ouser_r[b64d_pkg::UserByteValid] <= !cur_r.empty;
      ouser_r[b64d_pkg::UserStopped]   <= cur_r.eom && res_last && cur_r.stopped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      oval_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (cur_done) begin
        busy_r <= 1'b0;
        idx_r  <= 2'd0;
      end else if (advance) begin
        idx_r <= idx_r + 2'd1;
      end
      if (advance) begin
        oval_r <= 1'b1;
      end else if (out_tready) begin
        oval_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ouser_r;

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[b64d_pkg::UserByteValid] |-> out_tlast)
    else $error("empty marker without end of message");

  a_stop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[b64d_pkg::UserStopped] |-> out_tlast)
    else $error("stopped flag on a non-final result");

  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r < cur_r.nres)
    else $error("result index beyond burst");

endmodule
`default_nettype wire

// ===== rtl/core/base64_decoder.sv =====
// Top level of the streaming Base64 (RFC 4648) decoder.
`default_nettype none
// Streaming Base64 decoder. One ASCII character enters per transaction on the
// in_ channel, one decoded byte leaves per transaction on the out_ channel.
// A-Z, a-z, 0-9, '+' and '/' carry six bits each; every fourth one releases
// three bytes. The first other character ('=' padding included) stops
// decoding for the rest of the message. On the character flagged in_tlast a
// held partial group of two or three sextets releases one or two bytes; when
// no byte comes out, an empty end marker (byte_valid 0) is sent. The final
// result of a message carries out_tlast and, in tuser, the stopped-early flag.
// Rate: one character is accepted every cycle while the queue has room; the
// output side delivers one result per cycle while out_tready is high. A
// character may cause up to three results, so bursts sit in a four-entry
// queue between the classifier and the output serializer; in_tready drops
// only while that queue is full. Results leave through an output register.
module base64_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] in_char
  input  wire logic        in_tlast,    // in_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] data_byte
  output logic             out_tlast,   // end_of_message
  output logic [1:0]       out_tuser    // [0] byte_valid, [1] stopped_early
);

  b64d_pkg::b64d_entry_t push_entry, pop_entry;
  b64d_pkg::b64d_qstat_t q_stat;
  logic                  push, pop, accept;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Classifier and sextet gatherer
  b64d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_char (in_tdata),
    .in_last (in_tlast),
    .push    (push),
    .entry   (push_entry)
  );

  // Burst queue
  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (pop_entry),
    .stat     (q_stat)
  );

  // Serializer with registered output
  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_entry    (pop_entry),
    .q_stat     (q_stat),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
